@@ design/kfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package kfd_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned NalTypeW = 5;
	localparam int unsigned ReasonW = 2;
	localparam int unsigned DataBytes = 1;

	localparam logic [ByteW-1:0] StartZero = 8'h00;
	localparam logic [ByteW-1:0] StartOne = 8'h01;
	localparam logic [ByteW-1:0] NalTypeMask = 8'h1f;

	typedef enum logic [NalTypeW-1:0] {
		NAL_UNSPEC = 5'd0,
		NAL_IDR    = 5'd5,
		NAL_SPS    = 5'd7,
		NAL_PPS    = 5'd8,
		NAL_AUD    = 5'd9
	} nal_type_t;

	typedef enum logic [ReasonW-1:0] {
		RSN_IDR       = 2'd0,
		RSN_DELIMITER = 2'd1,
		RSN_OTHER_NAL = 2'd2,
		RSN_FRAME_END = 2'd3
	} reason_t;

	typedef struct packed {
		logic [1:0] zero_run;
		logic       header_next;
		logic       seen_sps;
		logic       seen_pps;
		logic       decided;
		logic       held_verdict;
		reason_t    held_reason;
	} scan_state_t;

	typedef struct packed {
		logic    is_keyframe;
		reason_t decided_by;
	} result_t;

endpackage

`default_nettype wire

@@ design/h264_annexb_keyframe_detect_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// A frame's last byte is held in the input register, and its result is registered
// in the output register once that register is free; it then waits for m_tready.
// Throughput: one byte per cycle; the input register advances every cycle, only a
// final byte waits for the output register to be free.
// Reset (arst_n low, asynchronous): input and output registers empty, per-frame
// scan state cleared.
module h264_annexb_keyframe_detect_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata, // [7:0] data_byte
	input  wire logic       s_tlast, // last_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata, // [0] is_keyframe
	output logic [1:0]      m_tuser  // [1:0] decided_by
);

	logic             valid_s1;
	logic [7:0]       data_s1;
	logic             last_s1;
	logic             advance;
	logic             out_free;
	kfd_pkg::result_t result;

	// hold a final byte until the output slot opens
	assign advance = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	kfd_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.result    (result)
	);

	kfd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && last_s1),
		.result   (result),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

@@ design/kfd_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kfd_scan (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic [7:0]       data_byte,
	input  wire logic             last_byte,
	output kfd_pkg::result_t      result
);

	kfd_pkg::scan_state_t state_q;
	kfd_pkg::scan_state_t state_nxt;
	kfd_pkg::nal_type_t   nal_type;

	assign nal_type = kfd_pkg::nal_type_t'(data_byte[kfd_pkg::NalTypeW-1:0]
		& kfd_pkg::NalTypeMask[kfd_pkg::NalTypeW-1:0]);

	always_comb begin
		state_nxt = state_q;
		result = '{is_keyframe: 1'b0, decided_by: kfd_pkg::RSN_FRAME_END};
		if (!state_q.decided) begin
			if (state_q.header_next) begin
				state_nxt.header_next = 1'b0;
				state_nxt.zero_run = 2'd0;
				// a header on the frame's final byte carries no weight
				if (!last_byte) begin
					case (nal_type)
						kfd_pkg::NAL_IDR: begin
							state_nxt.decided = 1'b1;
							state_nxt.held_verdict = 1'b1;
							state_nxt.held_reason = kfd_pkg::RSN_IDR;
						end
						kfd_pkg::NAL_AUD: begin
							state_nxt.decided = 1'b1;
							state_nxt.held_verdict = 1'b1;
							state_nxt.held_reason = kfd_pkg::RSN_DELIMITER;
						end
						kfd_pkg::NAL_SPS: begin
							state_nxt.seen_sps = 1'b1;
						end
						kfd_pkg::NAL_PPS: begin
							if (state_q.seen_sps) begin
								state_nxt.seen_pps = 1'b1;
							end else begin
								state_nxt.decided = 1'b1;
								state_nxt.held_verdict = 1'b0;
								state_nxt.held_reason = kfd_pkg::RSN_FRAME_END;
							end
						end
						kfd_pkg::NAL_UNSPEC: begin
						end
						default: begin
							state_nxt.decided = 1'b1;
							state_nxt.held_verdict = state_q.seen_sps & state_q.seen_pps;
							state_nxt.held_reason = kfd_pkg::RSN_OTHER_NAL;
						end
					endcase
				end
			end else if (data_byte == kfd_pkg::StartZero) begin
				// saturate at two zeros
				if (state_q.zero_run != 2'd2) begin
					state_nxt.zero_run = state_q.zero_run + 2'd1;
				end
			end else if (data_byte == kfd_pkg::StartOne && state_q.zero_run == 2'd2) begin
				state_nxt.header_next = 1'b1;
				state_nxt.zero_run = 2'd0;
			end else begin
				state_nxt.zero_run = 2'd0;
			end
		end
		if (last_byte) begin
			if (state_nxt.decided) begin
				result.is_keyframe = state_nxt.held_verdict;
				result.decided_by = state_nxt.held_reason;
			end else begin
				result.is_keyframe = state_nxt.seen_sps & state_nxt.seen_pps;
				result.decided_by = kfd_pkg::RSN_FRAME_END;
			end
			state_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (en) begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

@@ design/kfd_out_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kfd_out_stage (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     load,
	input  wire kfd_pkg::result_t         result,
	output logic                          free,
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic [kfd_pkg::ByteW*kfd_pkg::DataBytes-1:0] m_tdata, // [0] is_keyframe
	output logic [kfd_pkg::ReasonW-1:0]   m_tuser // [1:0] decided_by
);

	logic             valid_q;
	kfd_pkg::result_t result_q;

	// slot opens when empty or when the held result transfers this cycle
	assign free = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata = {{(kfd_pkg::ByteW*kfd_pkg::DataBytes-1){1'b0}}, result_q.is_keyframe};
	assign m_tuser = result_q.decided_by;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			result_q <= result;
		end
	end

endmodule

`default_nettype wire

@@ sim/kfd_verdict_checker.sv @@
`timescale 1ns / 1ps

module kfd_verdict_checker
	import kfd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	input  wire logic       s_tready,
	input  wire logic [7:0] s_tdata, // [7:0] data_byte
	input  wire logic       s_tlast, // last_byte
	input  wire logic       m_tvalid,
	input  wire logic       m_tready,
	input  wire logic [7:0] m_tdata, // [0] is_keyframe
	input  wire logic [1:0] m_tuser, // [1:0] decided_by
	output int              mismatches,
	output int              awaiting
);

	localparam logic [1:0] ZeroRunFull = 2'd2;
	localparam int ReportLimit = 10;

	scan_state_t scan;
	result_t verdict_q[$];
	int bad_count;

	// Advance the per-frame scan by one byte.
	function automatic scan_state_t scan_byte(scan_state_t st, logic [ByteW-1:0] b, logic last);
		scan_state_t nx;
		logic [ByteW-1:0] masked;
		logic [NalTypeW-1:0] nal;
		nx = st;
		masked = b & NalTypeMask;
		nal = masked[NalTypeW-1:0];
		if (!st.decided) begin
			if (st.header_next) begin
				nx.header_next = 1'b0;
				nx.zero_run = '0;
				// a header on the frame's final byte is dropped
				if (!last) begin
					case (nal)
						NAL_IDR: begin
							nx.decided = 1'b1;
							nx.held_verdict = 1'b1;
							nx.held_reason = RSN_IDR;
						end
						NAL_AUD: begin
							nx.decided = 1'b1;
							nx.held_verdict = 1'b1;
							nx.held_reason = RSN_DELIMITER;
						end
						NAL_SPS: nx.seen_sps = 1'b1;
						NAL_PPS: begin
							if (st.seen_sps) begin
								nx.seen_pps = 1'b1;
							end else begin
								nx.decided = 1'b1;
								nx.held_verdict = 1'b0;
								nx.held_reason = RSN_FRAME_END;
							end
						end
						NAL_UNSPEC: ;
						default: begin
							nx.decided = 1'b1;
							nx.held_verdict = st.seen_sps & st.seen_pps;
							nx.held_reason = RSN_OTHER_NAL;
						end
					endcase
				end
			end else if (b == StartZero) begin
				if (st.zero_run < ZeroRunFull)
					nx.zero_run = st.zero_run + 2'd1;
			end else if (b == StartOne && st.zero_run >= ZeroRunFull) begin
				nx.header_next = 1'b1;
				nx.zero_run = '0;
			end else begin
				nx.zero_run = '0;
			end
		end
		return nx;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		scan_state_t nx;
		if (!arst_n) begin
			scan = '0;
			verdict_q.delete();
			bad_count = 0;
		end else begin
			// results leave for older frames, so retire them first
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					if (bad_count < ReportLimit)
						$display("%0t: unexpected verdict transfer tdata=%h tuser=%0d",
							$realtime, m_tdata, m_tuser);
					bad_count++;
				end else begin
					want = verdict_q.pop_front();
					if (m_tdata !== {7'd0, want.is_keyframe} || m_tuser !== want.decided_by) begin
						if (bad_count < ReportLimit)
							$display("%0t: verdict mismatch: expected key=%0b by=%0d, got tdata=%h tuser=%0d",
								$realtime, want.is_keyframe, want.decided_by, m_tdata, m_tuser);
						bad_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				nx = scan_byte(scan, s_tdata, s_tlast);
				if (s_tlast) begin
					if (nx.decided) begin
						want.is_keyframe = nx.held_verdict;
						want.decided_by = nx.held_reason;
					end else begin
						want.is_keyframe = nx.seen_sps & nx.seen_pps;
						want.decided_by = RSN_FRAME_END;
					end
					verdict_q.push_back(want);
					nx = '0;
				end
				scan = nx;
			end
		end
		mismatches <= bad_count;
		awaiting <= verdict_q.size();
	end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import kfd_pkg::*;

	localparam int TargetBytes = 1550;
	localparam int WatchdogLimit = 5000;
	localparam int DrainCycles = 12;
	localparam logic [NalTypeW-1:0] NalSlice = 5'd1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;

	int mismatch_count;
	int awaiting;
	int stall_cycles = 0;

	logic [7:0] byte_q[$];
	logic last_q[$];
	logic [7:0] frame[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	h264_annexb_keyframe_detect_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	kfd_verdict_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.mismatches (mismatch_count),
		.awaiting   (awaiting)
	);

	// Move the current frame into the byte stream, flagging its final byte.
	task automatic queue_frame();
		foreach (frame[i]) begin
			byte_q.push_back(frame[i]);
			last_q.push_back(i == frame.size() - 1);
		end
		frame.delete();
	endtask

	function automatic logic [7:0] noisy_byte();
		case ($urandom_range(0, 5))
			0, 1: return StartZero;
			2: return StartOne;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic add_nal(logic [NalTypeW-1:0] nal);
		int zeros;
		int payload;
		zeros = $urandom_range(2, 4);
		payload = $urandom_range(0, 4);
		repeat (zeros) frame.push_back(StartZero);
		frame.push_back(StartOne);
		frame.push_back({3'($urandom), nal});
		repeat (payload) frame.push_back(noisy_byte());
	endtask

	function automatic logic [NalTypeW-1:0] pick_nal();
		case ($urandom_range(0, 9))
			0: return NAL_IDR;
			1: return NAL_AUD;
			2, 3: return NAL_SPS;
			4, 5: return NAL_PPS;
			6: return NAL_UNSPEC;
			default: return NalTypeW'($urandom);
		endcase
	endfunction

	task automatic build_random_frame();
		int kind;
		int n;
		int keep;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			// noise
			n = $urandom_range(1, 12);
			repeat (n) frame.push_back(noisy_byte());
		end else begin
			if ($urandom_range(0, 2) == 0) begin
				add_nal(NAL_SPS);
				add_nal(NAL_PPS);
			end
			n = $urandom_range(1, 4);
			repeat (n) add_nal(pick_nal());
			// broken: may cut the frame short
			if (kind == 1) begin
				keep = $urandom_range(1, frame.size());
				while (frame.size() > keep) void'(frame.pop_back());
			end
		end
		queue_frame();
	endtask

	task automatic build_stimulus();
		// delimiter behind an extra leading zero
		frame = '{StartZero, StartZero, StartZero, StartOne, {3'b000, NAL_AUD}, 8'hff};
		queue_frame();
		// SPS, PPS, then a slice: decided after parameter sets
		frame = '{StartZero, StartZero, StartOne, {3'b011, NAL_SPS},
			StartZero, StartZero, StartOne, {3'b011, NAL_PPS},
			StartZero, StartZero, StartOne, {3'b010, NalSlice}, 8'h80};
		queue_frame();
		// PPS without SPS decides false; the IDR after it is ignored
		frame = '{StartZero, StartZero, StartOne, {3'b011, NAL_PPS},
			StartZero, StartZero, StartOne, {3'b011, NAL_IDR}, 8'haa};
		queue_frame();
		// IDR header on the final byte does not count
		frame = '{StartZero, StartZero, StartOne, {3'b111, NAL_IDR}};
		queue_frame();
		// zero header is skipped and is not a zero of the next start code
		frame = '{StartZero, StartZero, StartOne, {3'b000, NAL_UNSPEC},
			StartZero, StartOne, {3'b011, NAL_IDR}, 8'h55};
		queue_frame();
		while (byte_q.size() < TargetBytes)
			build_random_frame();
	endtask

	// Receiver: switch among stall patterns.
	int rx_mode = 0;
	int rx_left = 0;
	int rx_tick = 0;
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(8, 80);
		end else begin
			rx_left <= rx_left - 1;
		end
		rx_tick <= rx_tick + 1;
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 2) != 0);
			2: m_tready <= (rx_tick % 4 == 0);
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WatchdogLimit) begin
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	initial begin
		int burst_left;
		int gap;
		burst_left = 0;
		build_stimulus();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (byte_q[i]) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				burst_left = $urandom_range(1, 40);
			end
			s_tvalid <= 1'b1;
			s_tdata <= byte_q[i];
			s_tlast <= last_q[i];
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			@(negedge clk);
			burst_left--;
		end
		s_tvalid <= 1'b0;
		while (awaiting != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
